@@ hdl/bal_pkg.sv @@
package bal_pkg;
  localparam int BlockSize = 32;
  localparam int IdxW = $clog2(BlockSize);
  localparam int CntW = $clog2(BlockSize + 1);

  typedef struct packed {
    logic [7:0] val;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] rank;
    logic [4:0] digit;
  } entry_t;
endpackage

@@ hdl/bal_front.sv @@
module bal_front import bal_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_sample,
  output logic q_valid,
  input  logic q_ready,
  output entry_t q_data
);
  localparam logic [1:0] S_FILL = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [7:0] store [BlockSize];
  logic [1:0] state;
  logic [CntW-1:0] fill;
  logic [IdxW-1:0] cur;
  logic [IdxW-1:0] scan;
  logic [IdxW-1:0] rank;
  logic [4:0] digit;
  logic [7:0] cv;
  logic [7:0] sv;
  logic lt;
  logic gt;

  assign in_ready = (state == S_FILL);
  assign cv = store[cur];
  assign sv = store[scan];
  assign lt = ($signed(sv) < $signed(cv)) || (sv == cv && scan < cur);
  assign gt = $signed(sv) > $signed(cv) && scan < cur;
  assign q_valid = (state == S_PUSH);
  assign q_data = '{val: cv, idx: cur, rank: rank, digit: digit};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      store[fill[IdxW-1:0]] <= in_sample;
    end
    if (rst) begin
      state <= S_FILL;
      fill <= '0;
      cur <= '0;
      scan <= '0;
      rank <= '0;
      digit <= '0;
    end else begin
      unique case (state)
        S_FILL: begin
          if (in_valid) begin
            if (fill == CntW'(BlockSize - 1)) begin
              fill <= '0;
              state <= S_SCAN;
              cur <= '0;
              scan <= '0;
              rank <= '0;
              digit <= '0;
            end else begin
              fill <= fill + 1'b1;
            end
          end
        end
        S_SCAN: begin
          rank <= rank + IdxW'(lt);
          digit <= digit + 5'(gt);
          scan <= scan + 1'b1;
          if (scan == IdxW'(BlockSize - 1)) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (q_ready) begin
            rank <= '0;
            digit <= '0;
            scan <= '0;
            cur <= cur + 1'b1;
            state <= (cur == IdxW'(BlockSize - 1)) ? S_FILL : S_SCAN;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end
endmodule

@@ hdl/bal_back.sv @@
module bal_back import bal_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  entry_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] out_value,
  output logic [IdxW-1:0] out_index,
  output logic [7:0] out_delta,
  output logic [4:0] out_digit,
  output logic out_last
);
  localparam logic LOAD = 1'b0;
  localparam logic EMIT = 1'b1;

  logic [7:0] vals [BlockSize];
  logic [IdxW-1:0] idxs [BlockSize];
  logic [4:0] digs [BlockSize];
  logic state;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] pos;
  logic [7:0] prev;
  logic rd_ok;
  logic rd_done;
  logic [7:0] rv;
  logic [IdxW-1:0] ri;
  logic [4:0] rdg;
  logic [IdxW-1:0] rpos;

  assign q_ready = (state == LOAD);
  assign rd_ok = (state == EMIT) && !rd_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      vals[q_data.rank] <= q_data.val;
      idxs[q_data.rank] <= q_data.idx;
      digs[q_data.rank] <= q_data.digit;
    end
    if (rd_ok) begin
      rv <= vals[pos];
      ri <= idxs[pos];
      rdg <= digs[pos];
      rpos <= pos;
    end
  end

  logic stage;
  assign out_valid = stage;
  assign out_value = rv;
  assign out_index = ri;
  assign out_digit = rdg;
  assign out_delta = (rpos == '0) ? 8'd0 : rv - prev;
  assign out_last = (rpos == IdxW'(BlockSize - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      cnt <= '0;
      pos <= '0;
      stage <= 1'b0;
      rd_done <= 1'b0;
      prev <= '0;
    end else begin
      if (stage && out_ready) begin
        prev <= rv;
      end
      if (rd_ok) begin
        stage <= 1'b1;
      end else if (out_ready) begin
        stage <= 1'b0;
      end
      unique case (state)
        LOAD: begin
          if (q_valid) begin
            if (cnt == CntW'(BlockSize - 1)) begin
              cnt <= '0;
              state <= EMIT;
              pos <= '0;
              rd_done <= 1'b0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        EMIT: begin
          if (rd_ok) begin
            pos <= pos + 1'b1;
            if (pos == IdxW'(BlockSize - 1)) begin
              rd_done <= 1'b1;
            end
          end
          if (rd_done && (!stage || out_ready)) begin
            state <= LOAD;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end
endmodule

@@ hdl/block_argsort_lehmer_coder_core.sv @@
// Block argsort with Lehmer digits.
// Input: s_axis word = one signed 8-bit sample; 32 samples form a block.
// After the 32nd sample the front end ranks every sample by a scan over
// the stored block, one compare per cycle, and hands each ranked sample
// off before the next scan, while input is held off (s_axis_tready low).
// Ranked entries go through a handoff into a rank-addressed buffer in the
// back end, which then plays out 32 words in sorted order, one per cycle
// while the receiver is ready, with m_axis_tlast on the last. The front
// accepts the next block as soon as the buffer has taken its entries; the
// buffer readout goes from its read port into a single output register.
// When the receiver stalls, the output register holds and readout stops;
// the front then stalls at its handoff.
// Reset (rst, synchronous) clears counters and states; partial blocks drop.
// Throughput is set by the rank scan, which follows the fill of each block;
// no new sample is taken until the whole block is ranked and handed off.
module block_argsort_lehmer_coder_core import bal_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] sample
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] value,[12:8] index,[20:13] delta,[25:21] digit
  output logic m_axis_tlast
);
  logic q_valid;
  logic q_ready;
  entry_t q_data;
  logic [7:0] value;
  logic [IdxW-1:0] index;
  logic [7:0] delta;
  logic [4:0] digit;

  bal_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_sample(s_axis_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  bal_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_value(value), .out_index(index), .out_delta(delta),
    .out_digit(digit), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, digit, delta, 5'(index), value};
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top import bal_pkg::*; ();

  localparam int WatchLimit = 20000;

  typedef struct {
    logic [7:0] value;
    logic [4:0] index;
    logic [7:0] delta;
    logic [4:0] digit;
    logic       last;
  } sorted_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;

  logic [7:0] sample_q[$];
  sorted_word_t sorted_q[$];
  logic signed [7:0] held_block[BlockSize];
  int fill_cnt = 0;
  int err_cnt = 0;
  int idle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit done = 1'b0;

  block_argsort_lehmer_coder_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // Stable ascending argsort of the held block with Lehmer digits.
  task automatic predict_sorted_block();
    int order[BlockSize];
    int r, gt;
    logic signed [7:0] prev;
    sorted_word_t w;
    for (int i = 0; i < BlockSize; i++) begin
      r = 0;
      for (int j = 0; j < BlockSize; j++)
        if (held_block[j] < held_block[i] || (held_block[j] == held_block[i] && j < i)) r++;
      order[r] = i;
    end
    prev = 0;
    for (int k = 0; k < BlockSize; k++) begin
      gt = 0;
      for (int j = 0; j < order[k]; j++)
        if (held_block[j] > held_block[order[k]]) gt++;
      w.value = held_block[order[k]];
      w.index = 5'(order[k]);
      w.delta = (k == 0) ? 8'd0 : 8'(held_block[order[k]] - prev);
      w.digit = 5'(gt);
      w.last = (k == BlockSize - 1);
      prev = held_block[order[k]];
      sorted_q.push_back(w);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        held_block[fill_cnt] = s_axis_tdata;
        fill_cnt = fill_cnt + 1;
        if (fill_cnt == BlockSize) begin
          fill_cnt = 0;
          predict_sorted_block();
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= sample_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sorted_word_t w;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sorted_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          w = sorted_q.pop_front();
          if (m_axis_tdata[7:0] !== w.value) report_mismatch("value", m_axis_tdata[7:0], w.value);
          if (m_axis_tdata[12:8] !== w.index) report_mismatch("index", m_axis_tdata[12:8], w.index);
          if (m_axis_tdata[20:13] !== w.delta)
            report_mismatch("delta", m_axis_tdata[20:13], w.delta);
          if (m_axis_tdata[25:21] !== w.digit)
            report_mismatch("digit", m_axis_tdata[25:21], w.digit);
          if (m_axis_tdata[31:26] !== 6'd0) report_mismatch("pad", m_axis_tdata[31:26], 0);
          if (m_axis_tlast !== w.last) report_mismatch("last", m_axis_tlast, w.last);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else if (!done) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchLimit) begin
        $display("watchdog timeout");
        $display("** block_argsort_lehmer_coder_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_block(input int kind);
    for (int i = 0; i < BlockSize; i++) begin
      case (kind)
        0: sample_q.push_back(8'h80);
        1: sample_q.push_back(8'h7f);
        2: sample_q.push_back(8'(i * 8 - 128));
        3: sample_q.push_back(8'(127 - i * 8));
        4: sample_q.push_back((i % 2) ? 8'h7f : 8'h80);
        5: sample_q.push_back(8'($urandom_range(3)));
        default: sample_q.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int blocks);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int b = 0; b < blocks; b++) push_block(($urandom_range(3) == 0) ? 5 : 6);
    wait (sample_q.size() == 0 && !s_axis_tvalid && sorted_q.size() == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k <= 4; k++) push_block(k);
    wait (sample_q.size() == 0 && !s_axis_tvalid && sorted_q.size() == 0);
    run_phase(0, 0, 2);
    run_phase(79, 0, 2);
    run_phase(0, 79, 2);
    run_phase(13, 13, 3);
    repeat (50) @(posedge clk);
    done = 1'b1;
    if (err_cnt == 0 && sorted_q.size() == 0) begin
      $display("** block_argsort_lehmer_coder_core: PASSED **");
    end else begin
      $display("** block_argsort_lehmer_coder_core: FAILED **");
    end
    $finish;
  end
endmodule
